@@ rtl/roi_code_decoder_defines.svh @@
// assertion macros for the region of interest code decoder
`ifndef ROI_CODE_DECODER_DEFINES_SVH
`define ROI_CODE_DECODER_DEFINES_SVH

// antecedent implies consequent in the same cycle, checked outside reset
`define ROI_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("roi code decoder check failed");

// condition holds at every edge outside reset
`define ROI_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("roi code decoder check failed");

`endif

@@ rtl/roi_pkg.sv @@
// types, constants and lookup functions of the region of interest code decoder
package roi_pkg;

	localparam int unsigned CODE_W    = 32;
	localparam int unsigned INDEX_W   = 29;
	localparam int unsigned REL_W     = 28;
	localparam int unsigned CHAMBER_W = 4;
	localparam int unsigned LEVEL_W   = 4;
	localparam int unsigned CELL_W    = 14;
	localparam int unsigned SUM_W     = 15;
	localparam int unsigned GRID_W    = 15;
	localparam int unsigned EDGE_W    = 16;

	localparam int unsigned NUM_CHAMBERS = 10;
	localparam int unsigned NUM_LEVELS   = 13;
	localparam int unsigned MAX_CHAMBER  = 12;

	typedef logic [CODE_W-1:0]    code_t;
	typedef logic [INDEX_W-1:0]   index_t;
	typedef logic [REL_W-1:0]     rel_t;
	typedef logic [CHAMBER_W-1:0] chamber_t;
	typedef logic [LEVEL_W-1:0]   level_t;
	typedef logic [CELL_W-1:0]    cell_t;
	typedef logic [SUM_W-1:0]     sum_t;
	typedef logic [GRID_W-1:0]    grid_t;
	typedef logic [EDGE_W-1:0]    edge_t;

	// first code of each chamber
	function automatic code_t chamber_base(chamber_t c);
		code_t r;
		case (c)
			4'd1:    r = 32'd357848422;
			4'd2:    r = 32'd715696844;
			4'd3:    r = 32'd1073545266;
			4'd4:    r = 32'd1431393688;
			4'd5:    r = 32'd1789242110;
			4'd6:    r = 32'd2147090532;
			4'd7:    r = 32'd2504938954;
			4'd8:    r = 32'd2862787376;
			4'd9:    r = 32'd3220635798;
			4'd10:   r = 32'd3578484220;
			4'd11:   r = 32'd3936332642;
			4'd12:   r = 32'd4294181064;
			default: r = '0;
		endcase
		return r;
	endfunction

	// first location index of each level
	function automatic index_t level_start(level_t l);
		index_t r;
		case (l)
			4'd1:    r = 29'd1;
			4'd2:    r = 29'd10;
			4'd3:    r = 29'd59;
			4'd4:    r = 29'd284;
			4'd5:    r = 29'd1245;
			4'd6:    r = 29'd5214;
			4'd7:    r = 29'd21343;
			4'd8:    r = 29'd86368;
			4'd9:    r = 29'd347489;
			4'd10:   r = 29'd1394018;
			4'd11:   r = 29'd5584227;
			4'd12:   r = 29'd22353252;
			4'd13:   r = 29'd89445733;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/roi_code_decoder.sv @@
// region of interest code decoder: seven stage pipeline from code word to grid box
//
// input: a code word is taken at a rising edge where start is high and busy is low.
// busy is always low, so a new word may be offered in every cycle.
// output: done is high for one cycle with the decoded word on the result ports;
// that word is taken at the edge ending the cycle, the receiver cannot hold it.
// pipeline: each word passes the seven register stages in order (chamber compare,
// chamber subtract, level compare, offset subtract, split into high and low halves,
// quotient correction, grid shift and add). throughput: one word per cycle.
// reset: arst_n clears every stage valid bit at once, words in flight are
// dropped and done stays low until new words come through.
// chamber_valid is low when the chamber is 10 or above; all other fields are
// still decoded from the remainder.
module roi_code_decoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  roi_pkg::code_t    roi_code,
	output logic              done,
	output roi_pkg::chamber_t chamber,
	output logic              chamber_valid,
	output roi_pkg::level_t   level,
	output roi_pkg::cell_t    cell_left,
	output roi_pkg::cell_t    cell_bottom,
	output roi_pkg::grid_t    grid_left,
	output roi_pkg::grid_t    grid_bottom,
	output roi_pkg::edge_t    grid_right,
	output roi_pkg::edge_t    grid_top
);
	import roi_pkg::*;

	logic [7:1] v_q;

	code_t    code_s1;
	chamber_t chamber_d;
	chamber_t chamber_s1, chamber_s2, chamber_s3, chamber_s4, chamber_s5, chamber_s6;
	index_t   index_s2, index_s3;
	level_t   level_d;
	level_t   level_s3, level_s4, level_s5, level_s6;
	rel_t     rel_s4;
	cell_t    high_s5;
	sum_t     sum_s5;
	sum_t     width_5;
	cell_t    row_s6, col_s6;
	level_t   coarse_6;
	grid_t    gl_6, gb_6;
	edge_t    span_6;

	chamber_t chamber_q;
	logic     chamber_valid_q;
	level_t   level_q;
	cell_t    cell_left_q, cell_bottom_q;
	grid_t    grid_left_q, grid_bottom_q;
	edge_t    grid_right_q, grid_top_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[6:1], start & ~busy};
		end
	end

	// chamber by compare against the chamber bases
	always_comb begin
		chamber_d = '0;
		for (int k = 1; k <= MAX_CHAMBER; k++) begin
			if (roi_code >= chamber_base(CHAMBER_W'(k))) begin
				chamber_d = CHAMBER_W'(k);
			end
		end
	end

	always_ff @(posedge clk) begin
		code_s1    <= roi_code;
		chamber_s1 <= chamber_d;
	end

	always_ff @(posedge clk) begin
		index_s2   <= INDEX_W'(code_s1 - chamber_base(chamber_s1));
		chamber_s2 <= chamber_s1;
	end

	// level by compare against the level offsets
	always_comb begin
		level_d = '0;
		for (int k = 1; k <= NUM_LEVELS; k++) begin
			if (index_s2 >= level_start(LEVEL_W'(k))) begin
				level_d = LEVEL_W'(k);
			end
		end
	end

	always_ff @(posedge clk) begin
		index_s3   <= index_s2;
		level_s3   <= level_d;
		chamber_s3 <= chamber_s2;
	end

	always_ff @(posedge clk) begin
		rel_s4     <= REL_W'(index_s3 - level_start(level_s3));
		level_s4   <= level_s3;
		chamber_s4 <= chamber_s3;
	end

	// split at bit level+1: x = a*(w+1) + b = a*w + (a+b)
	always_ff @(posedge clk) begin
		high_s5    <= CELL_W'(rel_s4 >> (level_s4 + 1'b1));
		sum_s5     <= SUM_W'(rel_s4 >> (level_s4 + 1'b1))
			+ SUM_W'(rel_s4 & ~({REL_W{1'b1}} << (level_s4 + 1'b1)));
		level_s5   <= level_s4;
		chamber_s5 <= chamber_s4;
	end

	assign width_5 = (SUM_W'(2) << level_s5) - SUM_W'(1);

	// a+b is at most twice the width
	always_ff @(posedge clk) begin
		if (sum_s5 >= {width_5[SUM_W-2:0], 1'b0}) begin
			row_s6 <= high_s5 + CELL_W'(2);
			col_s6 <= CELL_W'(sum_s5 - {width_5[SUM_W-2:0], 1'b0});
		end else if (sum_s5 >= width_5) begin
			row_s6 <= high_s5 + CELL_W'(1);
			col_s6 <= CELL_W'(sum_s5 - width_5);
		end else begin
			row_s6 <= high_s5;
			col_s6 <= CELL_W'(sum_s5);
		end
		level_s6   <= level_s5;
		chamber_s6 <= chamber_s5;
	end

	assign coarse_6 = LEVEL_W'(NUM_LEVELS) - level_s6;
	assign gl_6     = GRID_W'(col_s6) << coarse_6;
	assign gb_6     = GRID_W'(row_s6) << coarse_6;
	assign span_6   = EDGE_W'(2) << coarse_6;

	always_ff @(posedge clk) begin
		chamber_q       <= chamber_s6;
		chamber_valid_q <= (chamber_s6 < CHAMBER_W'(NUM_CHAMBERS));
		level_q         <= level_s6;
		cell_left_q     <= col_s6;
		cell_bottom_q   <= row_s6;
		grid_left_q     <= gl_6;
		grid_bottom_q   <= gb_6;
		grid_right_q    <= EDGE_W'(gl_6) + span_6;
		grid_top_q      <= EDGE_W'(gb_6) + span_6;
	end

	assign done          = v_q[7];
	assign chamber       = chamber_q;
	assign chamber_valid = chamber_valid_q;
	assign level         = level_q;
	assign cell_left     = cell_left_q;
	assign cell_bottom   = cell_bottom_q;
	assign grid_left     = grid_left_q;
	assign grid_bottom   = grid_bottom_q;
	assign grid_right    = grid_right_q;
	assign grid_top      = grid_top_q;

endmodule

@@ rtl/roi_checker.sv @@
// port checker for the region of interest code decoder and its bind
`include "roi_code_decoder_defines.svh"

module roi_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input roi_pkg::chamber_t chamber,
	input logic              chamber_valid,
	input roi_pkg::level_t   level,
	input roi_pkg::cell_t    cell_left,
	input roi_pkg::grid_t    grid_left,
	input roi_pkg::grid_t    grid_bottom,
	input roi_pkg::edge_t    grid_right,
	input roi_pkg::edge_t    grid_top
);
	import roi_pkg::*;

	// every word out comes from a word taken at the input
	`ROI_ASSERT_IMPL(a_done_from_start, done, $past(start && !busy, 7))
	`ROI_ASSERT_IMPL(a_chamber_flag, done, chamber_valid == (chamber < CHAMBER_W'(NUM_CHAMBERS)))
	`ROI_ASSERT_IMPL(a_box_order, done, (grid_right > EDGE_W'(grid_left)) && (grid_top > EDGE_W'(grid_bottom)))
	`ROI_ASSERT_IMPL(a_column_fits, done, (cell_left >> (level + 1'b1)) == '0)
	`ROI_ASSERT_ALWAYS(a_never_busy, !busy)

endmodule

bind roi_code_decoder roi_checker u_roi_checker (.*);

@@ sim/roi_code_decoder_checker.sv @@
// checker for the region of interest code decoder: predicts each decoded word and compares
module roi_code_decoder_checker
	import roi_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  code_t       roi_code,
	input  logic        done,
	input  chamber_t    chamber,
	input  logic        chamber_valid,
	input  level_t      level,
	input  cell_t       cell_left,
	input  cell_t       cell_bottom,
	input  grid_t       grid_left,
	input  grid_t       grid_bottom,
	input  edge_t       grid_right,
	input  edge_t       grid_top,
	output int unsigned pending,
	output int unsigned fail_count
);

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CODES_PER_CHAMBER = 357848422;

	typedef struct packed {
		chamber_t chamber;
		logic     chamber_valid;
		level_t   level;
		cell_t    cell_left;
		cell_t    cell_bottom;
		grid_t    grid_left;
		grid_t    grid_bottom;
		edge_t    grid_right;
		edge_t    grid_top;
	} box_t;

	box_t boxes_due[$];

	initial begin
		pending = 0;
		fail_count = 0;
	end

	function automatic box_t decode_box(code_t code);
		box_t b;
		int unsigned chamber_no, loc, lv, width, coarse, row, col, gl, gb, span;
		chamber_no = code / CODES_PER_CHAMBER;
		loc = code % CODES_PER_CHAMBER;
		lv = 0;
		width = 1;
		// walk up the levels, each one holds width squared locations
		while (lv < NUM_LEVELS && loc >= width * width) begin
			loc = loc - width * width;
			lv = lv + 1;
			width = (2 << lv) - 1;
		end
		coarse = NUM_LEVELS - lv;
		row = loc / width;
		col = loc % width;
		gl = col << coarse;
		gb = row << coarse;
		span = 2 << coarse;
		b.chamber = chamber_t'(chamber_no);
		b.chamber_valid = chamber_no < NUM_CHAMBERS;
		b.level = level_t'(lv);
		b.cell_left = cell_t'(col);
		b.cell_bottom = cell_t'(row);
		b.grid_left = grid_t'(gl);
		b.grid_bottom = grid_t'(gb);
		b.grid_right = edge_t'(gl + span);
		b.grid_top = edge_t'(gb + span);
		return b;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		fail_count = fail_count + 1;
	endtask

	task automatic check_field(input string name, input int unsigned got, input int unsigned want);
		if (got != want) begin
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
		end
	endtask

	always @(posedge clk) begin
		box_t want;
		if (arst_n) begin
			if (done) begin
				if (boxes_due.size() == 0) begin
					report_mismatch("decoded word with nothing outstanding");
				end else begin
					want = boxes_due.pop_front();
					check_field("chamber", chamber, want.chamber);
					check_field("chamber_valid", chamber_valid, want.chamber_valid);
					check_field("level", level, want.level);
					check_field("cell_left", cell_left, want.cell_left);
					check_field("cell_bottom", cell_bottom, want.cell_bottom);
					check_field("grid_left", grid_left, want.grid_left);
					check_field("grid_bottom", grid_bottom, want.grid_bottom);
					check_field("grid_right", grid_right, want.grid_right);
					check_field("grid_top", grid_top, want.grid_top);
				end
			end
			if (start && !busy) begin
				boxes_due.push_back(decode_box(roi_code));
			end
			pending <= boxes_due.size();
		end
	end

endmodule

@@ sim/roi_code_decoder_tb.sv @@
// testbench top for the region of interest code decoder: stimulus, watchdog and verdict
module roi_code_decoder_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import roi_pkg::*;

	localparam int unsigned CODES_PER_CHAMBER = 357848422;
	localparam int unsigned PHASE_WORDS = 425;
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned DRAIN_CYCLES = 16;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	code_t       roi_code = '0;
	logic        done;
	chamber_t    chamber;
	logic        chamber_valid;
	level_t      level;
	cell_t       cell_left;
	cell_t       cell_bottom;
	grid_t       grid_left;
	grid_t       grid_bottom;
	edge_t       grid_right;
	edge_t       grid_top;
	int unsigned pending;
	int unsigned fail_count;
	int unsigned quiet_cycles = 0;

	always #4 clk = ~clk;

	roi_code_decoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.roi_code(roi_code),
		.done(done),
		.chamber(chamber),
		.chamber_valid(chamber_valid),
		.level(level),
		.cell_left(cell_left),
		.cell_bottom(cell_bottom),
		.grid_left(grid_left),
		.grid_bottom(grid_bottom),
		.grid_right(grid_right),
		.grid_top(grid_top)
	);

	roi_code_decoder_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.roi_code(roi_code),
		.done(done),
		.chamber(chamber),
		.chamber_valid(chamber_valid),
		.level(level),
		.cell_left(cell_left),
		.cell_bottom(cell_bottom),
		.grid_left(grid_left),
		.grid_bottom(grid_bottom),
		.grid_right(grid_right),
		.grid_top(grid_top),
		.pending(pending),
		.fail_count(fail_count)
	);

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send_word(input code_t c, input int unsigned idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		roi_code <= c;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
	endtask

	// well-formed code: chosen chamber, level and cell, corners of the level favored
	function automatic code_t random_code();
		longint unsigned full;
		int unsigned ch, lv, width, offset, row, col, k;
		ch = $urandom_range(0, MAX_CHAMBER);
		lv = $urandom_range(0, NUM_LEVELS);
		width = (2 << lv) - 1;
		offset = 0;
		for (k = 0; k < lv; k++) begin
			offset = offset + ((2 << k) - 1) * ((2 << k) - 1);
		end
		case ($urandom_range(3))
			0: row = 0;
			1: row = width - 1;
			default: row = $urandom_range(0, width - 1);
		endcase
		case ($urandom_range(3))
			0: col = 0;
			1: col = width - 1;
			default: col = $urandom_range(0, width - 1);
		endcase
		full = longint'(ch) * CODES_PER_CHAMBER + offset + row * width + col;
		if (full > 64'hFFFF_FFFF) begin
			full = full - CODES_PER_CHAMBER;
		end
		return code_t'(full);
	endfunction

	initial begin
		code_t directed[$];
		int unsigned idle_pct[4];
		int unsigned p, n;
		directed = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd59, 32'd284, 32'd1245, 32'd5214,
			32'd21343, 32'd86368, 32'd347489, 32'd1394018, 32'd5584227, 32'd22353251,
			32'd22353252, 32'd89445733, 32'd357848421, 32'd357848422, 32'd3578484219,
			32'd3578484220, 32'd4294181064, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};
		idle_pct = '{0, 76, 0, 37};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) begin
			send_word(directed[i], 0);
		end
		wait_drained();
		for (p = 0; p < 4; p++) begin
			for (n = 0; n < PHASE_WORDS; n++) begin
				if ($urandom_range(3) == 0) begin
					send_word($urandom(), idle_pct[p]);
				end else begin
					send_word(random_code(), idle_pct[p]);
				end
			end
			// hold off until every decoded word is back
			wait_drained();
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
